FILE: rtl/core/srt_pkg.sv
// Package for the sorted record table: shared types, cell commands and result codes.
// Used by srt_cell and sorted_record_table; depends on nothing else.
`default_nettype none

package srt_pkg;

  // Default number of cells in the chain
  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SCORE_W = 8;
  localparam int unsigned AVG_W   = 9;
  localparam int unsigned STAT_W  = 2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_ENTRY    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // Operation codes of the input word
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  // Command broadcast to every cell in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score_a;
    logic [SCORE_W-1:0] score_b;
  } entry_t;

  // Control group from the sequencer to the cells
  typedef struct packed {
    cell_op_e op;
    entry_t   rec;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_record_table.sv
// Sorted record table: top level with the cell chain, sequencer and output register.
// Depends on srt_pkg and srt_cell.
//
// Keeps up to DEPTH records sorted by ascending unsigned key in a chain of cells. An insert
// word places its record ahead of the first entry with a key not smaller; a delete word
// removes the first entry with an equal key. After a successful operation that leaves entries,
// the whole table goes out in order, one word per entry, with last set on the final one;
// otherwise one status word (empty, not found, full) goes out. An input word is captured into a
// register and applied to the chain; then the entries are listed or the status word is sent.
// The listing rotates the chain through its head cell, one entry per cycle while the output
// is not stalled; the next input word is taken only after the last result word has been
// loaded into the output register.
`default_nettype none

module sorted_record_table #(
  parameter int unsigned DEPTH = srt_pkg::DEPTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [srt_pkg::KEY_W-1:0]     key_i,
  input  wire logic [srt_pkg::SCORE_W-1:0]   score_a_i,
  input  wire logic [srt_pkg::SCORE_W-1:0]   score_b_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [srt_pkg::STAT_W-1:0]         status_o,
  output logic [srt_pkg::KEY_W-1:0]          entry_key_o,
  output logic [srt_pkg::SCORE_W-1:0]        entry_score_a_o,
  output logic [srt_pkg::SCORE_W-1:0]        entry_score_b_o,
  output logic [srt_pkg::AVG_W-1:0]          avg_halves_o,
  output logic                               last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_STAT = 2'd3;

  logic [1:0]                  state_q, state_d;
  logic [CW-1:0]               fill_q, fill_d;
  logic [CW-1:0]               cnt_q, cnt_d;
  logic                        func_q;
  srt_pkg::entry_t             cmd_q;
  logic [srt_pkg::STAT_W-1:0]  code_q, code_d;

  logic                        out_vld_q, out_vld_d;
  logic [srt_pkg::STAT_W-1:0]  out_stat_q, out_stat_d;
  srt_pkg::entry_t             out_ent_q, out_ent_d;
  logic [srt_pkg::AVG_W-1:0]   out_avg_q, out_avg_d;
  logic                        out_last_q, out_last_d;

  srt_pkg::cell_ctl_t          ctl;
  srt_pkg::entry_t             ent_w [DEPTH];
  logic [DEPTH-1:0]            vld_w;
  logic [DEPTH-1:0]            lt_w;
  logic [DEPTH-1:0]            eq_w;

  logic                        accept;
  logic                        load;
  logic                        found;
  logic                        full;
  logic                        emit_last;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign load       = !out_vld_q || !out_stall_i;
  assign found      = |eq_w;
  assign full       = (fill_q == CW'(DEPTH));
  assign emit_last  = (CW'(cnt_q + 1'b1) == fill_q);

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            p_lt, p_vld, n_vld;
    srt_pkg::entry_t p_ent, n_ent;
    if (i == 0) begin : g_first
      assign p_lt  = 1'b1;
      assign p_vld = 1'b1;
      assign p_ent = ent_w[0];
    end else begin : g_mid
      assign p_lt  = lt_w[i-1];
      assign p_vld = vld_w[i-1];
      assign p_ent = ent_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign n_vld = 1'b0;
      assign n_ent = ent_w[i];
    end else begin : g_inner
      assign n_vld = vld_w[i+1];
      assign n_ent = ent_w[i+1];
    end
    srt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .prev_lt_i  (p_lt),
      .prev_vld_i (p_vld),
      .prev_ent_i (p_ent),
      .next_vld_i (n_vld),
      .next_ent_i (n_ent),
      .head_ent_i (ent_w[0]),
      .ent_o      (ent_w[i]),
      .vld_o      (vld_w[i]),
      .lt_o       (lt_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  // Sequencer: apply the word, then list the table or report a status
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    code_d     = code_q;
    ctl.op     = srt_pkg::CELL_HOLD;
    ctl.rec    = cmd_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_stat_d = out_stat_q;
    out_ent_d  = out_ent_q;
    out_avg_d  = out_avg_q;
    out_last_d = out_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cnt_d = '0;
        if (func_q == srt_pkg::FUNC_INSERT) begin
          if (full) begin
            code_d  = srt_pkg::ST_FULL;
            state_d = S_STAT;
          end else begin
            ctl.op  = srt_pkg::CELL_INSERT;
            fill_d  = CW'(fill_q + 1'b1);
            state_d = S_EMIT;
          end
        end else if (fill_q == '0) begin
          code_d  = srt_pkg::ST_EMPTY;
          state_d = S_STAT;
        end else if (!found) begin
          code_d  = srt_pkg::ST_NOTFOUND;
          state_d = S_STAT;
        end else begin
          ctl.op = srt_pkg::CELL_DELETE;
          fill_d = CW'(fill_q - 1'b1);
          if (fill_q == CW'(1)) begin
            code_d  = srt_pkg::ST_EMPTY;
            state_d = S_STAT;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (load) begin
          ctl.op     = srt_pkg::CELL_ROTATE;
          out_vld_d  = 1'b1;
          out_stat_d = srt_pkg::ST_ENTRY;
          out_ent_d  = ent_w[0];
          out_avg_d  = srt_pkg::AVG_W'(ent_w[0].score_a) + srt_pkg::AVG_W'(ent_w[0].score_b);
          out_last_d = emit_last;
          if (emit_last) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            cnt_d = CW'(cnt_q + 1'b1);
          end
        end
      end
      S_STAT: begin
        if (load) begin
          out_vld_d  = 1'b1;
          out_stat_d = code_q;
          out_ent_d  = '0;
          out_avg_d  = '0;
          out_last_d = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q        <= func_i;
      cmd_q.key     <= key_i;
      cmd_q.score_a <= score_a_i;
      cmd_q.score_b <= score_b_i;
    end
  end

  // Output word payload and status code
  always_ff @(posedge clk_i) begin
    out_stat_q <= out_stat_d;
    out_ent_q  <= out_ent_d;
    out_avg_q  <= out_avg_d;
    out_last_q <= out_last_d;
    code_q     <= code_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_stat_q;
  assign entry_key_o     = out_ent_q.key;
  assign entry_score_a_o = out_ent_q.score_a;
  assign entry_score_b_o = out_ent_q.score_b;
  assign avg_halves_o    = out_avg_q;
  assign last_o          = out_last_q;

  // Valid flags track the fill count
  a_fill_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_w) == 32'(fill_q))
    else $error("cell valid flags disagree with fill count");

  // Valid flags form a contiguous run from the head
  a_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_w + DEPTH'(1)))
    else $error("cell valid flags not contiguous");

  // Listing never runs past the fill
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (cnt_q < fill_q))
    else $error("listing index beyond fill");

  // Status words are single, final and zero filled
  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != srt_pkg::ST_ENTRY)) |->
      (last_o && (entry_key_o == '0) && (avg_halves_o == '0)))
    else $error("malformed status word");

endmodule

`default_nettype wire

FILE: rtl/core/srt_cell.sv
// One cell of the sorted record chain: holds one record and its valid flag.
// Depends on srt_pkg for the record type and the cell command.
`default_nettype none

module srt_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire srt_pkg::cell_ctl_t     ctl_i,
  input  wire logic                   prev_lt_i,
  input  wire logic                   prev_vld_i,
  input  wire srt_pkg::entry_t        prev_ent_i,
  input  wire logic                   next_vld_i,
  input  wire srt_pkg::entry_t        next_ent_i,
  input  wire srt_pkg::entry_t        head_ent_i,
  output srt_pkg::entry_t             ent_o,
  output logic                        vld_o,
  output logic                        lt_o,
  output logic                        eq_o
);

  srt_pkg::entry_t ent_q, ent_d;
  logic            vld_q, vld_d;

  // Compare the stored key against the broadcast key
  assign lt_o  = vld_q && (ent_q.key < ctl_i.rec.key);
  assign eq_o  = vld_q && (ent_q.key == ctl_i.rec.key);
  assign ent_o = ent_q;
  assign vld_o = vld_q;

  // Select the next content from self, neighbors, the new record or the head
  always_comb begin
    ent_d = ent_q;
    vld_d = vld_q;
    unique case (ctl_i.op)
      srt_pkg::CELL_HOLD: begin
      end
      srt_pkg::CELL_INSERT: begin
        if (!lt_o) begin
          ent_d = prev_lt_i ? ctl_i.rec : prev_ent_i;
          vld_d = vld_q | prev_vld_i;
        end
      end
      srt_pkg::CELL_DELETE: begin
        // at or past the first match: pull from the right
        if (vld_q && !lt_o) begin
          ent_d = next_ent_i;
          vld_d = next_vld_i;
        end
      end
      srt_pkg::CELL_ROTATE: begin
        if (vld_q && !next_vld_i) begin
          ent_d = head_ent_i;
        end else if (vld_q) begin
          ent_d = next_ent_i;
        end
      end
      default: begin
      end
    endcase
  end

  // Record payload
  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

endmodule

`default_nettype wire
